[rtl/core/upw_pkg.sv]
`timescale 1ns / 1ps

package upw_pkg;

  // Descriptor type codes
  localparam logic [7:0] IFACE_TYPE = 8'd4;
  localparam logic [7:0] EP_TYPE    = 8'd5;

  // Endpoint field decoding
  localparam logic [7:0] EP_DIR_IN  = 8'h80;
  localparam logic [1:0] XFER_BULK  = 2'd2;

  // Max packet size held after reset
  localparam logic [15:0] MPS_RESET = 16'd64;

  // Configuration register indexes
  localparam logic CFG_MATCH_CLASS  = 1'b0;
  localparam logic CFG_STD_SUBCLASS = 1'b1;

  localparam logic [7:0] MATCH_CLASS_RESET  = 8'd7;
  localparam logic [7:0] STD_SUBCLASS_RESET = 8'd1;

  typedef enum logic [1:0] {
    REASON_FOUND      = 2'd0,
    REASON_ZERO_LEN   = 2'd1,
    REASON_TOTAL_LEN  = 2'd2,
    REASON_STREAM_END = 2'd3
  } reason_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic        found;
    reason_e     end_reason;
    logic [7:0]  iface_number;
    logic [7:0]  iface_subclass;
    logic [7:0]  iface_protocol;
    logic        subclass_nonstandard;
    logic [7:0]  out_ep_address;
    logic [15:0] out_max_packet;
    logic [7:0]  in_ep_address;
    logic [15:0] in_max_packet;
  } out_item_t;

endpackage

[rtl/core/upw_stream_if.sv]
`timescale 1ns / 1ps

interface upw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/usb_printer_descriptor_walker.sv]
`timescale 1ns / 1ps

// Walks a USB configuration descriptor set, one byte per beat, looking for an
// interface of class match_class (printer by default). A beat with first_byte
// set restarts the walk; until then beats are dropped. The walk reports one
// result beat on the byte that ends it: success with the interface number,
// subclass, protocol and bulk OUT/IN endpoints of the first matched interface
// holding a bulk OUT endpoint, or failure (zero length, total length reached,
// stream end) with all capture fields zero. Bytes that do not end the walk
// produce nothing. Throughput is one byte per clock: the walker state is a
// single register bank updated by one pass of compare/capture logic from the
// input register, so one byte is retired every cycle the result register can
// take it. Max packet sizes survive a restart (64 after reset). The user must
// make configuration writes only while the block is idle; the block itself
// does not enforce this. No clearing pass is needed after reset.
module usb_printer_descriptor_walker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write port
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [7:0]                cfg_wdata_i,
  // descriptor bytes in, results out
  upw_stream_if.sink                in_if,
  upw_stream_if.source              out_if
);

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [7:0] match_class_q;
  logic [7:0] std_subclass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_class_q  <= upw_pkg::MATCH_CLASS_RESET;
      std_subclass_q <= upw_pkg::STD_SUBCLASS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        upw_pkg::CFG_MATCH_CLASS:  match_class_q  <= cfg_wdata_i;
        upw_pkg::CFG_STD_SUBCLASS: std_subclass_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and flow control
  // ---------------------------------------------------------------------------
  logic              in_vld_q;
  upw_pkg::in_item_t in_q;
  logic              out_vld_q;
  upw_pkg::out_item_t out_q;

  logic res_vld;   // byte in the input register ends the walk
  logic adv;       // byte in the input register is retired this cycle

  // Stall only when a result must go out and the result register is blocked
  assign adv            = in_vld_q && (!res_vld || !out_vld_q || out_if.ready);
  assign in_if.ready    = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_q <= in_if.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // Walker state
  // ---------------------------------------------------------------------------
  logic [15:0] set_off_q,   set_off_d;
  logic [15:0] total_len_q, total_len_d;
  logic [7:0]  doff_q,      doff_d;
  logic [7:0]  dlen_q,      dlen_d;
  logic [7:0]  dtype_q,     dtype_d;
  logic        capt_q,      capt_d;
  logic [7:0]  ep_seen_q,   ep_seen_d;
  logic [7:0]  ep_tgt_q,    ep_tgt_d;
  logic [31:0] scratch_q,   scratch_d;   // descriptor bytes 2..5
  logic [15:0] tail_q,      tail_d;      // descriptor bytes 6..7
  logic [7:0]  out_addr_q,  out_addr_d;
  logic [7:0]  in_addr_q,   in_addr_d;
  logic [15:0] out_mps_q,   out_mps_d;
  logic [15:0] in_mps_q,    in_mps_d;
  logic [23:0] iface_q,     iface_d;     // {protocol, subclass, number}
  logic        done_q,      done_d;

  logic            res_ok;
  upw_pkg::reason_e res_reason;

  always_comb begin
    logic [7:0] b;
    logic       stop;
    logic       ok;
    logic [1:0] lane;

    b    = in_q.data_byte;
    stop = 1'b0;
    ok   = 1'b0;
    lane = 2'd0;

    set_off_d   = set_off_q;
    total_len_d = total_len_q;
    doff_d      = doff_q;
    dlen_d      = dlen_q;
    dtype_d     = dtype_q;
    capt_d      = capt_q;
    ep_seen_d   = ep_seen_q;
    ep_tgt_d    = ep_tgt_q;
    scratch_d   = scratch_q;
    tail_d      = tail_q;
    out_addr_d  = out_addr_q;
    in_addr_d   = in_addr_q;
    out_mps_d   = out_mps_q;
    in_mps_d    = in_mps_q;
    iface_d     = iface_q;
    done_d      = done_q;

    res_vld     = 1'b0;
    res_ok      = 1'b0;
    res_reason  = upw_pkg::REASON_FOUND;

    // restart: max packet sizes are kept
    if (in_q.first_byte) begin
      set_off_d   = '0;
      total_len_d = '0;
      doff_d      = '0;
      dlen_d      = '0;
      dtype_d     = '0;
      capt_d      = 1'b0;
      ep_seen_d   = '0;
      ep_tgt_d    = '0;
      scratch_d   = '0;
      tail_d      = '0;
      out_addr_d  = '0;
      in_addr_d   = '0;
      iface_d     = '0;
      done_d      = 1'b0;
    end

    if (done_d) begin
      stop = 1'b1;
    end

    if (!stop) begin
      // total length sits at set bytes 2 and 3
      if (set_off_d == 16'd2) begin
        total_len_d[7:0] = b;
      end else if (set_off_d == 16'd3) begin
        total_len_d[15:8] = b;
      end
      if (set_off_d != 16'hFFFF) begin
        set_off_d = set_off_d + 16'd1;
      end

      if (doff_d == 8'd0) begin
        if (b == 8'd0) begin
          ok     = capt_d && (out_addr_d != 8'd0);
          capt_d = 1'b0;
          res_vld    = 1'b1;
          res_ok     = ok;
          res_reason = upw_pkg::REASON_ZERO_LEN;
          done_d     = 1'b1;
          stop       = 1'b1;
        end else begin
          dlen_d    = b;
          dtype_d   = '0;
          scratch_d = '0;
          tail_d    = '0;
        end
      end else if (doff_d == 8'd1) begin
        dtype_d = b;
        // next interface closes a running capture
        if (capt_d && b == upw_pkg::IFACE_TYPE) begin
          ok     = out_addr_d != 8'd0;
          capt_d = 1'b0;
          if (ok) begin
            res_vld    = 1'b1;
            res_ok     = 1'b1;
            res_reason = upw_pkg::REASON_FOUND;
            done_d     = 1'b1;
            stop       = 1'b1;
          end
        end
      end else if (doff_d inside {[8'd2:8'd5]}) begin
        lane = doff_d[1:0] - 2'd2;
        scratch_d[{lane, 3'b000} +: 8] = scratch_d[{lane, 3'b000} +: 8] | b;
      end else if (doff_d == 8'd6) begin
        tail_d[7:0] = tail_d[7:0] | b;
      end else if (doff_d == 8'd7) begin
        tail_d[15:8] = tail_d[15:8] | b;
      end
    end

    if (!stop) begin
      doff_d = doff_d + 8'd1;

      if (doff_d == dlen_d) begin
        // descriptor complete
        if (dtype_d == upw_pkg::IFACE_TYPE) begin
          if (scratch_d[31:24] == match_class_q) begin
            iface_d    = {tail_d, scratch_d[7:0]};
            out_addr_d = '0;
            in_addr_d  = '0;
            ep_seen_d  = '0;
            ep_tgt_d   = scratch_d[23:16];
            capt_d     = scratch_d[23:16] != 8'd0;
          end
        end else if (dtype_d == upw_pkg::EP_TYPE && capt_d) begin
          if (scratch_d[9:8] == upw_pkg::XFER_BULK) begin
            if ((scratch_d[7:0] & upw_pkg::EP_DIR_IN) != 8'd0) begin
              in_addr_d = scratch_d[7:0];
              in_mps_d  = scratch_d[31:16];
            end else begin
              out_addr_d = scratch_d[7:0];
              out_mps_d  = scratch_d[31:16];
            end
          end
          ep_seen_d = ep_seen_d + 8'd1;
        end

        // endpoint count reached
        if (capt_d && ep_seen_d >= ep_tgt_d) begin
          ok     = out_addr_d != 8'd0;
          capt_d = 1'b0;
          if (ok) begin
            res_vld    = 1'b1;
            res_ok     = 1'b1;
            res_reason = upw_pkg::REASON_FOUND;
            done_d     = 1'b1;
            stop       = 1'b1;
          end
        end

        if (!stop) begin
          doff_d = '0;
          if (({1'b0, set_off_d} + 17'd2) > {1'b0, total_len_d}) begin
            ok     = capt_d && (out_addr_d != 8'd0);
            capt_d = 1'b0;
            res_vld    = 1'b1;
            res_ok     = ok;
            res_reason = upw_pkg::REASON_TOTAL_LEN;
            done_d     = 1'b1;
            stop       = 1'b1;
          end
        end
      end
    end

    if (!stop && in_q.stream_end) begin
      ok     = capt_d && (out_addr_d != 8'd0);
      capt_d = 1'b0;
      res_vld    = 1'b1;
      res_ok     = ok;
      res_reason = upw_pkg::REASON_STREAM_END;
      done_d     = 1'b1;
    end

    // a beat that is not in the input register does nothing
    if (!in_vld_q) begin
      res_vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_off_q   <= '0;
      total_len_q <= '0;
      doff_q      <= '0;
      dlen_q      <= '0;
      dtype_q     <= '0;
      capt_q      <= 1'b0;
      ep_seen_q   <= '0;
      ep_tgt_q    <= '0;
      scratch_q   <= '0;
      tail_q      <= '0;
      out_addr_q  <= '0;
      in_addr_q   <= '0;
      out_mps_q   <= upw_pkg::MPS_RESET;
      in_mps_q    <= upw_pkg::MPS_RESET;
      iface_q     <= '0;
      done_q      <= 1'b1;   // idle until a first byte
    end else if (adv) begin
      set_off_q   <= set_off_d;
      total_len_q <= total_len_d;
      doff_q      <= doff_d;
      dlen_q      <= dlen_d;
      dtype_q     <= dtype_d;
      capt_q      <= capt_d;
      ep_seen_q   <= ep_seen_d;
      ep_tgt_q    <= ep_tgt_d;
      scratch_q   <= scratch_d;
      tail_q      <= tail_d;
      out_addr_q  <= out_addr_d;
      in_addr_q   <= in_addr_d;
      out_mps_q   <= out_mps_d;
      in_mps_q    <= in_mps_d;
      iface_q     <= iface_d;
      done_q      <= done_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  upw_pkg::out_item_t res_item;

  always_comb begin
    res_item = '0;
    res_item.found      = res_ok;
    res_item.end_reason = res_ok ? upw_pkg::REASON_FOUND : res_reason;
    if (res_ok) begin
      res_item.iface_number         = iface_d[7:0];
      res_item.iface_subclass       = iface_d[15:8];
      res_item.iface_protocol       = iface_d[23:16];
      res_item.subclass_nonstandard = iface_d[15:8] != std_subclass_q;
      res_item.out_ep_address       = out_addr_d;
      res_item.out_max_packet       = out_mps_d;
      res_item.in_ep_address        = in_addr_d;
      res_item.in_max_packet        = in_mps_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && res_vld) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_q <= res_item;
    end
  end

  assign out_if.valid   = out_vld_q;
  assign out_if.payload = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv) && $past(res_vld))
    else $error("result beat without a retired byte");

  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_vld |=> done_q)
    else $error("walk not closed after its result");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && done_q && !in_q.first_byte |-> !res_vld)
    else $error("result while idle");

  a_found_has_out_ep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.found |->
      out_q.out_ep_address != 8'd0 && out_q.end_reason == upw_pkg::REASON_FOUND)
    else $error("success without bulk OUT endpoint");

  a_fail_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.found |->
      out_q.iface_number == 8'd0 && out_q.out_ep_address == 8'd0 &&
      out_q.in_ep_address == 8'd0 && out_q.out_max_packet == 16'd0 &&
      out_q.end_reason != upw_pkg::REASON_FOUND)
    else $error("failure result carries capture fields");

endmodule

[dv/tb_usb_printer_descriptor_walker.sv]
`timescale 1ns / 1ps

module tb_usb_printer_descriptor_walker;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int SETTLE_MAX   = 2000;
  // output passes the input and result registers; leave some slack
  localparam int DRAIN_CYCLES = 8;
  localparam int N_PHASES     = 5;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  upw_stream_if #(.T(upw_pkg::in_item_t))  byte_if ();
  upw_stream_if #(.T(upw_pkg::out_item_t)) result_if ();

  usb_printer_descriptor_walker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (byte_if),
    .out_if      (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Walker model: our own copy of the register bank and the configuration.
  // ---------------------------------------------------------------------------
  logic [7:0]  match_cls;
  logic [7:0]  std_sub;

  logic [15:0] set_pos;       // byte offset within the set, saturating
  logic [15:0] total_len;     // wTotalLength as seen so far
  logic [7:0]  desc_pos;      // byte offset within the current descriptor
  logic [7:0]  desc_len;
  logic [7:0]  desc_kind;     // bDescriptorType
  logic        in_capture;
  logic [7:0]  eps_seen;
  logic [7:0]  eps_wanted;    // bNumEndpoints of the matched interface
  logic [31:0] field_bytes;   // descriptor bytes 2..5
  logic [15:0] tail_bytes;    // descriptor bytes 6..7
  logic [7:0]  cap_out_addr;
  logic [7:0]  cap_in_addr;
  logic [15:0] cap_out_mps;
  logic [15:0] cap_in_mps;
  logic [23:0] iface_info;    // number | subclass << 8 | protocol << 16
  logic        walk_idle;

  upw_pkg::out_item_t pending_results[$];
  logic [7:0]         set_data[$];
  upw_pkg::in_item_t  set_items[$];

  int unsigned n_errors;
  int unsigned n_items;       // beats the walker actually consumed
  int unsigned n_walks;       // result beats predicted
  int unsigned cycle_count;

  bit src_calm;
  bit sink_calm;
  int sink_hold;

  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic             typed;  // expected result written out by hand
    upw_pkg::reason_e why;
  } dir_row_t;

  // Idle byte, restart mid-walk, the three failure codes on one-byte sets,
  // then a minimal set: 4-byte config header, printer interface with one
  // endpoint, bulk OUT endpoint closing the capture.
  dir_row_t dir_rows [0:24] = '{
    '{8'hFF, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h09, 1'b1, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b1, 1'b0, 1'b1, upw_pkg::REASON_ZERO_LEN},
    '{8'h01, 1'b1, 1'b1, 1'b1, upw_pkg::REASON_TOTAL_LEN},
    '{8'hFF, 1'b1, 1'b1, 1'b1, upw_pkg::REASON_STREAM_END},
    '{8'h04, 1'b1, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h02, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h14, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h09, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h04, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h01, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h07, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h01, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h02, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h07, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h05, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h01, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h02, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h40, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND},
    '{8'h00, 1'b0, 1'b0, 1'b0, upw_pkg::REASON_FOUND}
  };

  function automatic logic [7:0] rb();
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly back-to-back, now and then a long hole
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Max packet sizes deliberately survive a restart.
  function automatic void restart_walk();
    set_pos      = '0;
    total_len    = '0;
    desc_pos     = '0;
    desc_len     = '0;
    desc_kind    = '0;
    in_capture   = 1'b0;
    eps_seen     = '0;
    eps_wanted   = '0;
    field_bytes  = '0;
    tail_bytes   = '0;
    cap_out_addr = '0;
    cap_in_addr  = '0;
    iface_info   = '0;
    walk_idle    = 1'b0;
  endfunction

  // Drops the capture whatever the outcome; true if it holds a bulk OUT ep.
  function automatic bit close_capture();
    bit ok;
    ok = in_capture && (cap_out_addr != 8'd0);
    in_capture = 1'b0;
    return ok;
  endfunction

  function automatic bit emit_result(input bit ok, input upw_pkg::reason_e why,
                                     output upw_pkg::out_item_t res);
    res = '0;
    walk_idle = 1'b1;
    if (ok) begin
      res.found                = 1'b1;
      res.end_reason           = upw_pkg::REASON_FOUND;
      res.iface_number         = iface_info[7:0];
      res.iface_subclass       = iface_info[15:8];
      res.iface_protocol       = iface_info[23:16];
      res.subclass_nonstandard = (iface_info[15:8] != std_sub);
      res.out_ep_address       = cap_out_addr;
      res.out_max_packet       = cap_out_mps;
      res.in_ep_address        = cap_in_addr;
      res.in_max_packet        = cap_in_mps;
    end else begin
      res.end_reason = why;
    end
    return 1'b1;
  endfunction

  // One descriptor byte through the walker; returns 1 when it ends the walk.
  function automatic bit walk_byte(input upw_pkg::in_item_t it,
                                   output upw_pkg::out_item_t res);
    logic [7:0] b;
    res = '0;
    b = it.data_byte;
    if (it.first_byte) restart_walk();
    if (walk_idle) return 1'b0;

    if (set_pos == 16'd2) total_len[7:0] = b;
    else if (set_pos == 16'd3) total_len[15:8] = b;
    if (set_pos != 16'hFFFF) set_pos++;

    if (desc_pos == 8'd0) begin
      if (b == 8'd0)
        return emit_result(close_capture(), upw_pkg::REASON_ZERO_LEN, res);
      desc_len    = b;
      desc_kind   = '0;
      field_bytes = '0;
      tail_bytes  = '0;
    end else if (desc_pos == 8'd1) begin
      desc_kind = b;
      // next interface closes a running capture straight away
      if (in_capture && b == upw_pkg::IFACE_TYPE) begin
        if (close_capture()) return emit_result(1'b1, upw_pkg::REASON_FOUND, res);
      end
    end else if (desc_pos <= 8'd5) begin
      field_bytes[8 * (int'(desc_pos) - 2) +: 8] = b;
    end else if (desc_pos == 8'd6) begin
      tail_bytes[7:0] = b;
    end else if (desc_pos == 8'd7) begin
      tail_bytes[15:8] = b;
    end
    desc_pos++;

    if (desc_pos == desc_len) begin
      if (desc_kind == upw_pkg::IFACE_TYPE) begin
        if (field_bytes[31:24] == match_cls) begin
          iface_info   = {tail_bytes, field_bytes[7:0]};
          cap_out_addr = '0;
          cap_in_addr  = '0;
          eps_seen     = '0;
          eps_wanted   = field_bytes[23:16];
          in_capture   = (eps_wanted != 8'd0);
        end
      end else if (desc_kind == upw_pkg::EP_TYPE && in_capture) begin
        // any transfer type counts toward bNumEndpoints
        if (field_bytes[9:8] == upw_pkg::XFER_BULK) begin
          if ((field_bytes[7:0] & upw_pkg::EP_DIR_IN) != 8'd0) begin
            cap_in_addr = field_bytes[7:0];
            cap_in_mps  = field_bytes[31:16];
          end else begin
            cap_out_addr = field_bytes[7:0];
            cap_out_mps  = field_bytes[31:16];
          end
        end
        eps_seen++;
      end
      if (in_capture && eps_seen >= eps_wanted) begin
        if (close_capture()) return emit_result(1'b1, upw_pkg::REASON_FOUND, res);
      end
      desc_pos = '0;
      if (32'(set_pos) + 32'd2 > 32'(total_len))
        return emit_result(close_capture(), upw_pkg::REASON_TOTAL_LEN, res);
    end

    if (it.stream_end)
      return emit_result(close_capture(), upw_pkg::REASON_STREAM_END, res);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (n_errors < 50)
      $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    upw_pkg::out_item_t got;
    upw_pkg::out_item_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with none pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", got.found, want.found);
        if (got.end_reason !== want.end_reason)
          report_mismatch("end_reason", got.end_reason, want.end_reason);
        if (got.iface_number !== want.iface_number)
          report_mismatch("iface_number", got.iface_number, want.iface_number);
        if (got.iface_subclass !== want.iface_subclass)
          report_mismatch("iface_subclass", got.iface_subclass, want.iface_subclass);
        if (got.iface_protocol !== want.iface_protocol)
          report_mismatch("iface_protocol", got.iface_protocol, want.iface_protocol);
        if (got.subclass_nonstandard !== want.subclass_nonstandard)
          report_mismatch("subclass_nonstandard", got.subclass_nonstandard,
                          want.subclass_nonstandard);
        if (got.out_ep_address !== want.out_ep_address)
          report_mismatch("out_ep_address", got.out_ep_address, want.out_ep_address);
        if (got.out_max_packet !== want.out_max_packet)
          report_mismatch("out_max_packet", got.out_max_packet, want.out_max_packet);
        if (got.in_ep_address !== want.in_ep_address)
          report_mismatch("in_ep_address", got.in_ep_address, want.in_ep_address);
        if (got.in_max_packet !== want.in_max_packet)
          report_mismatch("in_max_packet", got.in_max_packet, want.in_max_packet);
      end
    end
  end

  // Result sink: random stalls, now and then a calm stretch.
  always @(negedge clk_i) begin
    if (sink_hold == 0 && !sink_calm && $urandom_range(0, 3) == 0)
      sink_hold = pick_gap();
    if (sink_hold != 0) begin
      sink_hold--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One beat: optional hole, drive at the falling edge, wait for the
  // handshake, then step the model. A hand-typed row overrides the model's
  // result but the model still advances.
  task automatic send_byte(input upw_pkg::in_item_t it, input bit typed,
                           input upw_pkg::out_item_t typed_res);
    int                 gap;
    bit                 skip;
    bit                 got;
    upw_pkg::out_item_t res;
    gap = src_calm ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i) byte_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    byte_if.valid   <= 1'b1;
    byte_if.payload <= it;
    do @(posedge clk_i); while (!byte_if.ready);
    skip = walk_idle && !it.first_byte;
    got  = walk_byte(it, res);
    if (!skip) n_items++;
    if (typed) begin
      pending_results.push_back(typed_res);
      n_walks++;
    end else if (got) begin
      pending_results.push_back(res);
      n_walks++;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
    if (idx == upw_pkg::CFG_MATCH_CLASS) match_cls = val;
    else std_sub = val;
  endtask

  // Drop valid, wait for every pending result, then let the pipe drain.
  task automatic settle();
    int waited;
    @(negedge clk_i) byte_if.valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < SETTLE_MAX) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch("results never delivered", pending_results.size(), 0);
      pending_results.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_desc(input int len, input logic [7:0] body[$]);
    set_data.push_back(8'(len));
    for (int i = 1; i < len; i++)
      set_data.push_back((i - 1 < body.size()) ? body[i - 1] : rb());
  endtask

  // Builds one descriptor set: mostly a well-formed config header followed by
  // interfaces and endpoints with random content, occasionally plain noise.
  task automatic build_set();
    int                n_ep;
    int                len;
    int                end_at;
    int                restart_at;
    logic [15:0]       tot;
    logic [15:0]       mps;
    logic [7:0]        cls;
    logic [7:0]        sub;
    logic [7:0]        proto;
    logic [7:0]        addr;
    logic [7:0]        attr;
    logic [7:0]        kind;
    upw_pkg::in_item_t it;
    set_data.delete();
    set_items.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 40)) set_data.push_back(rb());
    end else begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 9;
      add_desc(len, '{8'h02, 8'h00, 8'h00, 8'h01, 8'h01, rb(), 8'h80, 8'h32});
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       kind = 8'h21;
            1:       kind = 8'h24;
            2:       kind = 8'h0B;
            default: kind = rb();
          endcase
          add_desc($urandom_range(2, 10), '{kind, rb(), rb(), rb(), rb()});
        end
        // stray zero length where a descriptor should start
        if ($urandom_range(0, 19) == 0) set_data.push_back(8'h00);
        cls   = ($urandom_range(0, 9) < 7) ? match_cls : rb();
        sub   = ($urandom_range(0, 1) == 0) ? std_sub : rb();
        proto = ($urandom_range(0, 4) == 0) ? rb() : 8'($urandom_range(1, 3));
        n_ep  = $urandom_range(0, 3);
        len   = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : 9;
        add_desc(len, '{upw_pkg::IFACE_TYPE, rb(), rb(), 8'(n_ep), cls, sub, proto,
                        rb()});
        // endpoint count that disagrees with bNumEndpoints
        if ($urandom_range(0, 4) == 0) n_ep = $urandom_range(0, 4);
        repeat (n_ep) begin
          if ($urandom_range(0, 2) == 0)
            addr = rb();
          else
            addr = {1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(0, 15))};
          attr = ($urandom_range(0, 9) < 7)
                   ? {6'($urandom_range(0, 63)), upw_pkg::XFER_BULK}
                   : rb();
          mps  = ($urandom_range(0, 1) == 0) ? (16'd8 << $urandom_range(0, 6))
                                              : 16'($urandom_range(0, 65535));
          kind = ($urandom_range(0, 19) == 0) ? rb() : upw_pkg::EP_TYPE;
          len  = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 10) : 7;
          add_desc(len, '{kind, addr, attr, mps[7:0], mps[15:8], rb()});
        end
      end
      case ($urandom_range(0, 6))
        0:       tot = 16'($urandom_range(0, set_data.size()));
        1:       tot = 16'($urandom_range(0, 65535));
        default: tot = 16'(set_data.size());
      endcase
      // wTotalLength sits at set bytes 2 and 3 whatever the header length
      if (set_data.size() > 3) begin
        set_data[2] = tot[7:0];
        set_data[3] = tot[15:8];
      end
    end
    case ($urandom_range(0, 9))
      8:       end_at = $urandom_range(0, set_data.size() - 1);
      9:       end_at = -1;
      default: end_at = set_data.size() - 1;
    endcase
    restart_at = -1;
    if (set_data.size() > 1 && $urandom_range(0, 29) == 0)
      restart_at = $urandom_range(1, set_data.size() - 1);
    foreach (set_data[i]) begin
      it.data_byte  = set_data[i];
      it.first_byte = (i == 0) || (i == restart_at);
      it.stream_end = (i == end_at);
      set_items.push_back(it);
    end
  endtask

  // Feed the set until the walk ends; sometimes trail a few ignored bytes.
  task automatic run_set(input bit force_calm);
    upw_pkg::in_item_t stray;
    src_calm  = force_calm || ($urandom_range(0, 4) == 0);
    sink_calm = ($urandom_range(0, 4) == 0);
    foreach (set_items[i]) begin
      send_byte(set_items[i], 1'b0, '0);
      if (walk_idle) break;
    end
    if (walk_idle && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        stray.data_byte  = rb();
        stray.first_byte = 1'b0;
        stray.stream_end = 1'($urandom_range(0, 1));
        send_byte(stray, 1'b0, '0);
      end
    end
  endtask

  initial begin
    upw_pkg::in_item_t  it;
    upw_pkg::out_item_t typed_res;
    logic [7:0]         cls;
    logic [7:0]         sub;
    int unsigned        items0;
    int unsigned        walks0;

    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    result_if.ready = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = upw_pkg::CFG_MATCH_CLASS;
    cfg_wdata_i     = '0;
    src_calm        = 1'b0;
    sink_calm       = 1'b0;
    sink_hold       = 0;

    // model state after reset: idle until a first byte, sizes at 64
    match_cls = upw_pkg::MATCH_CLASS_RESET;
    std_sub   = upw_pkg::STD_SUBCLASS_RESET;
    restart_walk();
    cap_out_mps = upw_pkg::MPS_RESET;
    cap_in_mps  = upw_pkg::MPS_RESET;
    walk_idle   = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed rows run on the reset configuration
    foreach (dir_rows[r]) begin
      it.data_byte  = dir_rows[r].data;
      it.first_byte = dir_rows[r].first;
      it.stream_end = dir_rows[r].last;
      typed_res            = '0;
      typed_res.end_reason = dir_rows[r].why;
      send_byte(it, dir_rows[r].typed, typed_res);
    end
    settle();

    // random sets under several configurations, extremes first
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          cls = 8'h00;
          sub = 8'hFF;
        end
        1: begin
          cls = 8'hFF;
          sub = 8'h00;
        end
        N_PHASES - 1: begin
          cls = upw_pkg::MATCH_CLASS_RESET;
          sub = upw_pkg::STD_SUBCLASS_RESET;
        end
        default: begin
          cls = rb();
          sub = rb();
        end
      endcase
      write_reg(upw_pkg::CFG_MATCH_CLASS, cls);
      write_reg(upw_pkg::CFG_STD_SUBCLASS, sub);
      items0 = n_items;
      walks0 = n_walks;
      while (n_items - items0 < 100 || n_walks - walks0 < 8) begin
        build_set();
        run_set(1'b0);
      end
      settle();
    end

    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
